// ===== hdl/tfta_pkg.sv =====
// Shared widths, register codes, reset values and types of the trade flow accumulator.
package tfta_pkg;

	localparam int TIME_W    = 17;
	localparam int SIDE_W    = 2;
	localparam int PRICE_W   = 32;
	localparam int VOL_W     = 32;
	localparam int SUM_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 17;

	// Direction codes of the incoming trade.
	localparam logic [SIDE_W-1:0] SIDE_BUY  = 2'd0;
	localparam logic [SIDE_W-1:0] SIDE_SELL = 2'd1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_AUCTION_BEGIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONTINUOUS_BEGIN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_AUCTION_AFTER = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SESSION_END         = 2'd3;

	// Reset values of the auction windows, in seconds of day.
	localparam logic [CFG_W-1:0] RST_OPEN_AUCTION_BEGIN  = 17'd33300;
	localparam logic [CFG_W-1:0] RST_CONTINUOUS_BEGIN    = 17'd34200;
	localparam logic [CFG_W-1:0] RST_CLOSE_AUCTION_AFTER = 17'd53820;
	localparam logic [CFG_W-1:0] RST_SESSION_END         = 17'd54000;

	// Resolved trade direction after the tick rule.
	typedef enum logic [1:0] {
		CLS_BUY,
		CLS_SELL,
		CLS_SPLIT
	} trade_class_t;

	// Control of one accumulator: advance takes the addend, clear empties it.
	typedef struct packed {
		logic advance;
		logic clear;
	} acc_ctl_t;

endpackage

// ===== hdl/tfta_trade_if.sv =====
// Request channel that carries one trade.
interface tfta_trade_if;
	import tfta_pkg::*;

	logic                valid;
	logic                ready;
	logic [TIME_W-1:0]   trade_time;
	logic [SIDE_W-1:0]   side_code;
	logic [PRICE_W-1:0]  trade_price;
	logic [VOL_W-1:0]    trade_volume;
	logic                last_trade;

	modport source (
		output valid, trade_time, side_code, trade_price, trade_volume, last_trade,
		input  ready
	);
	modport sink (
		input  valid, trade_time, side_code, trade_price, trade_volume, last_trade,
		output ready
	);
endinterface

// ===== hdl/tfta_total_if.sv =====
// Request channel that carries the day's totals.
interface tfta_total_if;
	import tfta_pkg::*;

	logic              valid;
	logic              ready;
	logic [SUM_W-1:0]  buy_volume;
	logic [SUM_W-1:0]  buy_amount;
	logic [SUM_W-1:0]  sell_volume;
	logic [SUM_W-1:0]  sell_amount;
	logic [SUM_W-1:0]  opening_volume;
	logic [SUM_W-1:0]  closing_volume;

	modport source (
		output valid, buy_volume, buy_amount, sell_volume, sell_amount,
		       opening_volume, closing_volume,
		input  ready
	);
	modport sink (
		input  valid, buy_volume, buy_amount, sell_volume, sell_amount,
		       opening_volume, closing_volume,
		output ready
	);
endinterface

// ===== hdl/tfta_sat_acc.sv =====
// One saturating 64-bit accumulator with clear.
module tfta_sat_acc (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tfta_pkg::acc_ctl_t         ctl,
	input  logic [tfta_pkg::SUM_W-1:0] addend,
	output logic [tfta_pkg::SUM_W-1:0] sum_next
);
	import tfta_pkg::*;

	logic [SUM_W-1:0] sum_q;
	logic [SUM_W:0]   wide_sum;

	// Add with carry out; a carry pins the total at all ones.
	assign wide_sum = {1'b0, sum_q} + {1'b0, addend};
	assign sum_next = wide_sum[SUM_W] ? {SUM_W{1'b1}} : wide_sum[SUM_W-1:0];

	// Take the new total, or empty the accumulator after the day's last trade.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.advance) begin
			sum_q <= ctl.clear ? '0 : sum_next;
		end
	end
endmodule

// ===== hdl/trade_flow_tick_rule_accumulator.sv =====
// Top level of the tick rule trade flow accumulator.
//
// Trades arrive on the trade_in channel, one request per trade; the day's
// totals leave on the total_out channel, one request after each trade that
// is marked last. Trades with an unknown direction are classified against
// the previous price; equal prices split the volume between buy and sell.
// The auction windows are set over the cfg_we / cfg_index / cfg_data port
// by the user while the block is idle; the block does not enforce this.
//
// A trade is taken every cycle while the pipeline is not stalled. It passes
// an input register, a stage with the 31 x 32 bit price multiplier, a stage
// that forms the addends, and then the saturating accumulators; the totals
// for a last trade are loaded into the output register, which holds them
// until they are taken. Trades keep flowing while totals wait, and only a
// new last trade that reaches the accumulators while the output register
// is still full stops the pipeline and drops trade_in.ready.
// Reset empties the pipeline and the accumulators, forgets the previous
// price and loads the default auction windows.
module trade_flow_tick_rule_accumulator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tfta_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tfta_pkg::CFG_W-1:0]     cfg_data,
	tfta_trade_if.sink                     trade_in,
	tfta_total_if.source                   total_out
);
	import tfta_pkg::*;

	// Configuration registers.
	logic [CFG_W-1:0] open_begin_q;
	logic [CFG_W-1:0] cont_begin_q;
	logic [CFG_W-1:0] close_after_q;
	logic [CFG_W-1:0] session_end_q;

	// Pipeline control.
	logic advance;
	logic stall;
	logic v_s1, v_s2, v_s3;

	// Stage 1: registered trade.
	logic [TIME_W-1:0]  time_s1;
	logic [SIDE_W-1:0]  side_s1;
	logic [PRICE_W-1:0] price_s1;
	logic [VOL_W-1:0]   vol_s1;
	logic               last_s1;
	logic [PRICE_W-1:0] prev_price_q;

	logic [PRICE_W-1:0]     ref_price;
	trade_class_t           cls_c;
	logic                   open_hit_c;
	logic                   close_hit_c;
	logic [2*PRICE_W-2:0]   half_prod_c;

	// Stage 2: class and half product.
	trade_class_t           cls_s2;
	logic [2*PRICE_W-2:0]   half_prod_s2;
	logic [PRICE_W-1:0]     price_s2;
	logic [VOL_W-1:0]       vol_s2;
	logic                   open_hit_s2;
	logic                   close_hit_s2;
	logic                   last_s2;

	logic [PRICE_W-1:0] odd_price;
	logic [SUM_W-1:0]   full_amt;
	logic [SUM_W-1:0]   rest_amt;
	logic [VOL_W-1:0]   half_vol;
	logic [VOL_W-1:0]   rest_vol;
	logic [SUM_W-1:0]   buy_vol_add_c, buy_amt_add_c, sell_vol_add_c, sell_amt_add_c;
	logic [SUM_W-1:0]   open_add_c, close_add_c;

	// Stage 3: addends for the accumulators.
	logic [SUM_W-1:0] buy_vol_add_s3, buy_amt_add_s3, sell_vol_add_s3, sell_amt_add_s3;
	logic [SUM_W-1:0] open_add_s3, close_add_s3;
	logic             last_s3;

	acc_ctl_t         acc_ctl;
	logic [SUM_W-1:0] buy_vol_next, buy_amt_next, sell_vol_next, sell_amt_next;
	logic [SUM_W-1:0] open_next, close_next;

	// Output register.
	logic             out_valid_q;
	logic [SUM_W-1:0] buy_vol_out_q, buy_amt_out_q, sell_vol_out_q, sell_amt_out_q;
	logic [SUM_W-1:0] open_out_q, close_out_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_begin_q  <= RST_OPEN_AUCTION_BEGIN;
			cont_begin_q  <= RST_CONTINUOUS_BEGIN;
			close_after_q <= RST_CLOSE_AUCTION_AFTER;
			session_end_q <= RST_SESSION_END;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OPEN_AUCTION_BEGIN:  open_begin_q  <= cfg_data;
				REG_CONTINUOUS_BEGIN:    cont_begin_q  <= cfg_data;
				REG_CLOSE_AUCTION_AFTER: close_after_q <= cfg_data;
				REG_SESSION_END:         session_end_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline stops only when a last trade meets a full output register that is not being taken.
	assign stall          = v_s3 && last_s3 && out_valid_q && !total_out.ready;
	assign advance        = !stall;
	assign trade_in.ready = advance;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= trade_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (advance) begin
			time_s1  <= trade_in.trade_time;
			side_s1  <= trade_in.side_code;
			price_s1 <= trade_in.trade_price;
			vol_s1   <= trade_in.trade_volume;
			last_s1  <= trade_in.last_trade & trade_in.valid;
		end
	end

	// Previous price; forgotten after the day's last trade.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_price_q <= '0;
		end else if (advance && v_s1) begin
			prev_price_q <= last_s1 ? '0 : price_s1;
		end
	end

	// Tick rule: without a previous price the trade compares with itself.
	assign ref_price = (prev_price_q == '0) ? price_s1 : prev_price_q;

	always_comb begin
		if (side_s1 == SIDE_BUY) begin
			cls_c = CLS_BUY;
		end else if (side_s1 == SIDE_SELL) begin
			cls_c = CLS_SELL;
		end else if (price_s1 > ref_price) begin
			cls_c = CLS_BUY;
		end else if (price_s1 < ref_price) begin
			cls_c = CLS_SELL;
		end else begin
			cls_c = CLS_SPLIT;
		end
	end

	// Auction window checks.
	assign open_hit_c  = (time_s1 >= open_begin_q) && (time_s1 < cont_begin_q);
	assign close_hit_c = (time_s1 > close_after_q) && (time_s1 <= session_end_q);

	// Half volume times price; the full amount is rebuilt from it next stage.
	assign half_prod_c = (2*PRICE_W-1)'(vol_s1[VOL_W-1:1]) * (2*PRICE_W-1)'(price_s1);

	always_ff @(posedge clk) begin
		if (advance) begin
			cls_s2       <= cls_c;
			half_prod_s2 <= half_prod_c;
			price_s2     <= price_s1;
			vol_s2       <= vol_s1;
			open_hit_s2  <= open_hit_c;
			close_hit_s2 <= close_hit_c;
			last_s2      <= last_s1 & v_s1;
		end
	end

	// Amounts: full = 2 * half product + odd price, rest = half product + odd price.
	assign odd_price = vol_s2[0] ? price_s2 : '0;
	assign full_amt  = {half_prod_s2, 1'b0} + {{(SUM_W-PRICE_W){1'b0}}, odd_price};
	assign rest_amt  = {1'b0, half_prod_s2} + {{(SUM_W-PRICE_W){1'b0}}, odd_price};
	assign half_vol  = {1'b0, vol_s2[VOL_W-1:1]};
	assign rest_vol  = vol_s2 - half_vol;

	// Addend selection by class.
	always_comb begin
		buy_vol_add_c  = '0;
		buy_amt_add_c  = '0;
		sell_vol_add_c = '0;
		sell_amt_add_c = '0;
		case (cls_s2)
			CLS_BUY: begin
				buy_vol_add_c = SUM_W'(vol_s2);
				buy_amt_add_c = full_amt;
			end
			CLS_SELL: begin
				sell_vol_add_c = SUM_W'(vol_s2);
				sell_amt_add_c = full_amt;
			end
			CLS_SPLIT: begin
				buy_vol_add_c  = SUM_W'(half_vol);
				buy_amt_add_c  = {1'b0, half_prod_s2};
				sell_vol_add_c = SUM_W'(rest_vol);
				sell_amt_add_c = rest_amt;
			end
			default: ;
		endcase
	end

	assign open_add_c  = open_hit_s2  ? SUM_W'(vol_s2) : '0;
	assign close_add_c = close_hit_s2 ? SUM_W'(vol_s2) : '0;

	always_ff @(posedge clk) begin
		if (advance) begin
			buy_vol_add_s3  <= buy_vol_add_c;
			buy_amt_add_s3  <= buy_amt_add_c;
			sell_vol_add_s3 <= sell_vol_add_c;
			sell_amt_add_s3 <= sell_amt_add_c;
			open_add_s3     <= open_add_c;
			close_add_s3    <= close_add_c;
			last_s3         <= last_s2 & v_s2;
		end
	end

	// Accumulators.
	assign acc_ctl.advance = advance && v_s3;
	assign acc_ctl.clear   = last_s3;

	tfta_sat_acc u_buy_vol (
		.clk(clk), .arst_n(arst_n), .ctl(acc_ctl), .addend(buy_vol_add_s3),
		.sum_next(buy_vol_next)
	);
	tfta_sat_acc u_buy_amt (
		.clk(clk), .arst_n(arst_n), .ctl(acc_ctl), .addend(buy_amt_add_s3),
		.sum_next(buy_amt_next)
	);
	tfta_sat_acc u_sell_vol (
		.clk(clk), .arst_n(arst_n), .ctl(acc_ctl), .addend(sell_vol_add_s3),
		.sum_next(sell_vol_next)
	);
	tfta_sat_acc u_sell_amt (
		.clk(clk), .arst_n(arst_n), .ctl(acc_ctl), .addend(sell_amt_add_s3),
		.sum_next(sell_amt_next)
	);
	tfta_sat_acc u_open_vol (
		.clk(clk), .arst_n(arst_n), .ctl(acc_ctl), .addend(open_add_s3),
		.sum_next(open_next)
	);
	tfta_sat_acc u_close_vol (
		.clk(clk), .arst_n(arst_n), .ctl(acc_ctl), .addend(close_add_s3),
		.sum_next(close_next)
	);

	// Output register: loaded by a last trade, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc_ctl.advance && last_s3) begin
			out_valid_q <= 1'b1;
		end else if (total_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_ctl.advance && last_s3) begin
			buy_vol_out_q  <= buy_vol_next;
			buy_amt_out_q  <= buy_amt_next;
			sell_vol_out_q <= sell_vol_next;
			sell_amt_out_q <= sell_amt_next;
			open_out_q     <= open_next;
			close_out_q    <= close_next;
		end
	end

	assign total_out.valid          = out_valid_q;
	assign total_out.buy_volume     = buy_vol_out_q;
	assign total_out.buy_amount     = buy_amt_out_q;
	assign total_out.sell_volume    = sell_vol_out_q;
	assign total_out.sell_amount    = sell_amt_out_q;
	assign total_out.opening_volume = open_out_q;
	assign total_out.closing_volume = close_out_q;

	// The input side waits only on a full, stalled output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		!trade_in.ready |-> (total_out.valid && !total_out.ready))
		else $error("trade_in.ready low without a stalled result");

	// A result appears only after a last trade left the accumulators.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(total_out.valid) |-> $past(v_s3 && last_s3))
		else $error("result raised without a last trade");

	// The previous price is forgotten after a last trade.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && v_s1 && last_s1) |=> (prev_price_q == '0))
		else $error("previous price kept across a day boundary");

	// A stalled last trade keeps the pipeline frozen.
	assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> (v_s3 && last_s3))
		else $error("last trade lost during stall");
endmodule

// ===== tb/sv/tfta_flow_checker.sv =====
// Checker that predicts the day totals from accepted trades and compares them with the block.
`timescale 1ns / 100ps

module tfta_flow_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tfta_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tfta_pkg::CFG_W-1:0]     cfg_data,
	tfta_trade_if                          trade_mon,
	tfta_total_if                          total_mon,
	output int                             mismatch_count,
	output int                             days_awaited
);
	import tfta_pkg::*;

	typedef struct packed {
		logic [SUM_W-1:0] buy_volume;
		logic [SUM_W-1:0] buy_amount;
		logic [SUM_W-1:0] sell_volume;
		logic [SUM_W-1:0] sell_amount;
		logic [SUM_W-1:0] opening_volume;
		logic [SUM_W-1:0] closing_volume;
	} day_totals_t;

	// Totals of closed days that have not left the block yet, oldest first.
	day_totals_t totals_due[$];
	day_totals_t day_running;
	day_totals_t oldest_day;
	logic [PRICE_W-1:0] tick_price;
	logic [CFG_W-1:0] open_begin;
	logic [CFG_W-1:0] cont_begin;
	logic [CFG_W-1:0] close_after;
	logic [CFG_W-1:0] sess_end;
	int mismatches = 0;

	assign mismatch_count = mismatches;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [SUM_W-1:0] b);
		logic [SUM_W:0] total;
		total = {1'b0, a} + {1'b0, b};
		return total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
	endfunction

	task automatic check_field(input string name, input logic [SUM_W-1:0] want,
			input logic [SUM_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Classify one trade by the tick rule and add it to the running day.
	task automatic book_trade(input logic [TIME_W-1:0] sec, input logic [SIDE_W-1:0] side,
			input logic [PRICE_W-1:0] price, input logic [VOL_W-1:0] vol,
			input logic closes_day);
		trade_class_t cls;
		logic [PRICE_W-1:0] against;
		logic [VOL_W-1:0] buy_part;
		logic [VOL_W-1:0] sell_part;

		// Without a known previous price the trade is compared with itself.
		against = (tick_price == '0) ? price : tick_price;
		if (side == SIDE_BUY)
			cls = CLS_BUY;
		else if (side == SIDE_SELL)
			cls = CLS_SELL;
		else if (price > against)
			cls = CLS_BUY;
		else if (price < against)
			cls = CLS_SELL;
		else
			cls = CLS_SPLIT;

		// A neutral trade gives the floor half to buy and the rest to sell.
		case (cls)
			CLS_BUY: begin
				buy_part  = vol;
				sell_part = '0;
			end
			CLS_SELL: begin
				buy_part  = '0;
				sell_part = vol;
			end
			default: begin
				buy_part  = vol >> 1;
				sell_part = vol - (vol >> 1);
			end
		endcase

		day_running.buy_volume  = sat_add(day_running.buy_volume, SUM_W'(buy_part));
		day_running.buy_amount  = sat_add(day_running.buy_amount,
			SUM_W'(buy_part) * SUM_W'(price));
		day_running.sell_volume = sat_add(day_running.sell_volume, SUM_W'(sell_part));
		day_running.sell_amount = sat_add(day_running.sell_amount,
			SUM_W'(sell_part) * SUM_W'(price));

		// Auction windows; a window whose start is not below its end stays empty.
		if (sec >= open_begin && sec < cont_begin)
			day_running.opening_volume = sat_add(day_running.opening_volume, SUM_W'(vol));
		if (sec > close_after && sec <= sess_end)
			day_running.closing_volume = sat_add(day_running.closing_volume, SUM_W'(vol));

		tick_price = price;

		// The last trade closes the day and forgets the previous price.
		if (closes_day) begin
			totals_due.push_back(day_running);
			day_running = '0;
			tick_price  = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			totals_due.delete();
			day_running  = '0;
			tick_price   = '0;
			open_begin   = RST_OPEN_AUCTION_BEGIN;
			cont_begin   = RST_CONTINUOUS_BEGIN;
			close_after  = RST_CLOSE_AUCTION_AFTER;
			sess_end     = RST_SESSION_END;
			days_awaited <= 0;
		end else begin
			// Totals leaving now were booked at an earlier edge, so check them first.
			if (total_mon.valid && total_mon.ready) begin
				if (totals_due.size() == 0) begin
					$error("day totals request with no closed day waiting");
					mismatches++;
				end else begin
					oldest_day = totals_due.pop_front();
					check_field("buy_volume", oldest_day.buy_volume, total_mon.buy_volume);
					check_field("buy_amount", oldest_day.buy_amount, total_mon.buy_amount);
					check_field("sell_volume", oldest_day.sell_volume, total_mon.sell_volume);
					check_field("sell_amount", oldest_day.sell_amount, total_mon.sell_amount);
					check_field("opening_volume", oldest_day.opening_volume,
						total_mon.opening_volume);
					check_field("closing_volume", oldest_day.closing_volume,
						total_mon.closing_volume);
				end
			end

			if (trade_mon.valid && trade_mon.ready)
				book_trade(trade_mon.trade_time, trade_mon.side_code, trade_mon.trade_price,
					trade_mon.trade_volume, trade_mon.last_trade);

			// Window registers take effect for trades accepted after the write.
			if (cfg_we) begin
				case (cfg_index)
					REG_OPEN_AUCTION_BEGIN:  open_begin  = cfg_data;
					REG_CONTINUOUS_BEGIN:    cont_begin  = cfg_data;
					REG_CLOSE_AUCTION_AFTER: close_after = cfg_data;
					REG_SESSION_END:         sess_end    = cfg_data;
					default: ;
				endcase
			end

			days_awaited <= totals_due.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top of the trade flow accumulator: clock, reset, trade stimulus and verdict.
`timescale 1ns / 100ps

module tb;
	import tfta_pkg::*;

	// Direction codes that leave the trade to the tick rule.
	localparam logic [SIDE_W-1:0] SIDE_UNKNOWN_A = 2'd2;
	localparam logic [SIDE_W-1:0] SIDE_UNKNOWN_B = 2'd3;
	localparam int SEGMENT_ITEMS = 233;
	localparam int SEGMENTS      = 6;
	localparam int DRAIN_CYCLES  = 8;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   mismatch_count;
	int                   days_awaited;
	int                   send_idle_pct = 9;
	int                   recv_idle_pct = 87;
	int                   segment_trades;
	logic [CFG_W-1:0]     window_cfg [4];
	logic [PRICE_W-1:0]   price_walk;

	tfta_trade_if trade_ch ();
	tfta_total_if total_ch ();

	trade_flow_tick_rule_accumulator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.trade_in  (trade_ch),
		.total_out (total_ch)
	);

	tfta_flow_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.trade_mon      (trade_ch),
		.total_mon      (total_ch),
		.mismatch_count (mismatch_count),
		.days_awaited   (days_awaited)
	);

	// 4 ns clock.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Hand one trade request over, with random idle cycles ahead of it.
	task automatic send_trade(input logic [TIME_W-1:0] sec, input logic [SIDE_W-1:0] side,
			input logic [PRICE_W-1:0] price, input logic [VOL_W-1:0] vol,
			input logic closes_day);
		while ($urandom_range(99) < send_idle_pct) begin
			trade_ch.valid <= 1'b0;
			@(posedge clk);
		end
		trade_ch.valid        <= 1'b1;
		trade_ch.trade_time   <= sec;
		trade_ch.side_code    <= side;
		trade_ch.trade_price  <= price;
		trade_ch.trade_volume <= vol;
		trade_ch.last_trade   <= closes_day;
		@(posedge clk);
		while (!trade_ch.ready)
			@(posedge clk);
	endtask

	task automatic write_window(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we     <= 1'b1;
		cfg_index  <= idx;
		cfg_data   <= val;
		window_cfg[idx] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Stop sending and wait until every closed day has left and the pipeline is empty.
	task automatic drain();
		trade_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (days_awaited != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One trading day of random trades; prices mostly walk so the tick rule sees all outcomes.
	task automatic send_random_day();
		int day_len;
		int pick;
		logic [TIME_W-1:0] sec;
		logic [SIDE_W-1:0] side;
		logic [PRICE_W-1:0] price;
		logic [VOL_W-1:0] vol;

		day_len = ($urandom_range(9) == 0) ? 1 : $urandom_range(40, 2);
		for (int n = 1; n <= day_len; n++) begin
			// Times cluster on the window edges, with some beyond the day.
			pick = $urandom_range(9);
			if (pick < 3)
				sec = TIME_W'(window_cfg[CFG_IDX_W'($urandom_range(1))] +
					$urandom_range(6) - 3);
			else if (pick < 6)
				sec = TIME_W'(window_cfg[CFG_IDX_W'($urandom_range(3, 2))] +
					$urandom_range(6) - 3);
			else if (pick < 9)
				sec = TIME_W'($urandom_range(86399));
			else
				sec = TIME_W'($urandom_range(131071));

			side = SIDE_W'($urandom_range(3));

			pick = $urandom_range(99);
			if (pick < 45)
				price = price_walk + $urandom_range(4) - 2;
			else if (pick < 65)
				price = price_walk;
			else if (pick < 69)
				price = '0;
			else if (pick < 73)
				price = '1;
			else if (pick < 85)
				price = $urandom_range(200000, 1);
			else
				price = $urandom;
			price_walk = price;

			pick = $urandom_range(99);
			if (pick < 55)
				vol = $urandom_range(1000);
			else if (pick < 75)
				vol = $urandom;
			else if (pick < 82)
				vol = '1;
			else if (pick < 88)
				vol = '0;
			else
				vol = $urandom_range(15);

			send_trade(sec, side, price, vol, n == day_len);
			segment_trades++;
		end
	endtask

	// Result side: ready low for the configured share of cycles.
	initial begin
		total_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			total_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		logic [CFG_W-1:0] lo_sec;
		logic [CFG_W-1:0] hi_sec;

		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = REG_OPEN_AUCTION_BEGIN;
		cfg_data              = '0;
		trade_ch.valid        = 1'b0;
		trade_ch.trade_time   = '0;
		trade_ch.side_code    = SIDE_BUY;
		trade_ch.trade_price  = '0;
		trade_ch.trade_volume = '0;
		trade_ch.last_trade   = 1'b0;
		window_cfg[REG_OPEN_AUCTION_BEGIN]  = RST_OPEN_AUCTION_BEGIN;
		window_cfg[REG_CONTINUOUS_BEGIN]    = RST_CONTINUOUS_BEGIN;
		window_cfg[REG_CLOSE_AUCTION_AFTER] = RST_CLOSE_AUCTION_AFTER;
		window_cfg[REG_SESSION_END]         = RST_SESSION_END;
		price_walk = 32'd10000;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed day under the reset windows: first trade with no previous price,
		// window edges, up, down and equal ticks, explicit sides against the tick.
		send_trade(RST_OPEN_AUCTION_BEGIN, SIDE_UNKNOWN_A, 32'd10000, 32'd7, 1'b0);
		send_trade(TIME_W'(RST_CONTINUOUS_BEGIN - 1), SIDE_UNKNOWN_B, 32'd10010, 32'd100,
			1'b0);
		send_trade(RST_CONTINUOUS_BEGIN, SIDE_UNKNOWN_A, 32'd10005, 32'd50, 1'b0);
		send_trade(RST_CLOSE_AUCTION_AFTER, SIDE_UNKNOWN_B, 32'd10005, 32'd1, 1'b0);
		send_trade(TIME_W'(RST_CLOSE_AUCTION_AFTER + 1), SIDE_BUY, 32'd9000, 32'd20, 1'b0);
		send_trade(RST_SESSION_END, SIDE_SELL, 32'd9500, 32'd30, 1'b0);
		// A zero price leaves no previous price for the next unknown trade.
		send_trade(TIME_W'(RST_SESSION_END + 1), SIDE_UNKNOWN_A, 32'd0, 32'd40, 1'b0);
		send_trade(17'd1000, SIDE_UNKNOWN_B, 32'd5, 32'd0, 1'b0);
		send_trade(17'd0, SIDE_UNKNOWN_A, 32'd5, '1, 1'b1);
		// A one-trade day at full scale, then amounts driven into saturation.
		send_trade(17'd86399, SIDE_UNKNOWN_B, '1, '1, 1'b1);
		send_trade(RST_OPEN_AUCTION_BEGIN, SIDE_BUY, '1, '1, 1'b0);
		send_trade(RST_OPEN_AUCTION_BEGIN, SIDE_BUY, '1, '1, 1'b0);
		send_trade(RST_OPEN_AUCTION_BEGIN, SIDE_SELL, '1, '1, 1'b0);
		send_trade(RST_OPEN_AUCTION_BEGIN, SIDE_SELL, '1, '1, 1'b0);
		send_trade('1, SIDE_UNKNOWN_A, '1, '1, 1'b1);
		send_trade(17'd86399, SIDE_BUY, 32'd1, 32'd1, 1'b1);
		send_trade(17'd12, SIDE_UNKNOWN_B, 32'd0, 32'd3, 1'b1);

		// Random days, each segment under its own windows and idle pattern.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain();
			case (seg)
				0: begin
					write_window(REG_OPEN_AUCTION_BEGIN, RST_OPEN_AUCTION_BEGIN);
					write_window(REG_CONTINUOUS_BEGIN, RST_CONTINUOUS_BEGIN);
					write_window(REG_CLOSE_AUCTION_AFTER, RST_CLOSE_AUCTION_AFTER);
					write_window(REG_SESSION_END, RST_SESSION_END);
				end
				1: begin
					write_window(REG_OPEN_AUCTION_BEGIN, '0);
					write_window(REG_CONTINUOUS_BEGIN, '0);
					write_window(REG_CLOSE_AUCTION_AFTER, '0);
					write_window(REG_SESSION_END, '0);
				end
				2: begin
					write_window(REG_OPEN_AUCTION_BEGIN, '0);
					write_window(REG_CONTINUOUS_BEGIN, '1);
					write_window(REG_CLOSE_AUCTION_AFTER, '0);
					write_window(REG_SESSION_END, '1);
				end
				3: begin
					// Both windows start above their end and must stay empty.
					write_window(REG_OPEN_AUCTION_BEGIN, 17'd60000);
					write_window(REG_CONTINUOUS_BEGIN, 17'd30000);
					write_window(REG_CLOSE_AUCTION_AFTER, 17'd70000);
					write_window(REG_SESSION_END, 17'd20000);
				end
				4: begin
					lo_sec = CFG_W'($urandom_range(43199));
					hi_sec = CFG_W'(lo_sec + $urandom_range(3600, 1));
					write_window(REG_OPEN_AUCTION_BEGIN, lo_sec);
					write_window(REG_CONTINUOUS_BEGIN, hi_sec);
					lo_sec = CFG_W'($urandom_range(80000, 43200));
					hi_sec = CFG_W'(lo_sec + $urandom_range(3600, 1));
					write_window(REG_CLOSE_AUCTION_AFTER, lo_sec);
					write_window(REG_SESSION_END, hi_sec);
				end
				default: begin
					write_window(REG_OPEN_AUCTION_BEGIN, CFG_W'($urandom_range(131071)));
					write_window(REG_CONTINUOUS_BEGIN, CFG_W'($urandom_range(131071)));
					write_window(REG_CLOSE_AUCTION_AFTER, CFG_W'($urandom_range(131071)));
					write_window(REG_SESSION_END, CFG_W'($urandom_range(131071)));
				end
			endcase

			case (seg / 2)
				0: begin
					send_idle_pct = 9;
					recv_idle_pct = 87;
				end
				1: begin
					send_idle_pct = 87;
					recv_idle_pct = 9;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase

			segment_trades = 0;
			while (segment_trades < SEGMENT_ITEMS)
				send_random_day();
		end

		drain();
		if (mismatch_count == 0 && days_awaited == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
